// ===== rtl/core/rsfc_pkg.sv =====
// Package for the ray / sphere far-exit pipeline: field widths, stream packing
// offsets, register map and the payload types shared by the core and its root unit.
// No dependencies.
`default_nettype none

package rsfc_pkg;

  localparam int POS_W    = 24;
  localparam int DIR_W    = 16;
  localparam int RAD_W    = 23;
  localparam int DIR_FRAC = 14;

  localparam int OFF_W  = POS_W + 1;
  localparam int PD_W   = OFF_W + DIR_W;
  localparam int PSQ_W  = 2 * OFF_W;
  localparam int PM_W   = PSQ_W - 1;
  localparam int DOT_W  = PD_W + 2;
  localparam int MAG_W  = PM_W + 1;
  localparam int T_W    = DOT_W - 2 - DIR_FRAC;
  localparam int TSQ_W  = 2 * T_W;
  localparam int R2_W   = 2 * RAD_W;
  localparam int RS_W   = TSQ_W + 3;
  localparam int RADIC_W = RS_W - 1;
  localparam int ROOT_W = RADIC_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int LEN_W  = ROOT_W + 1;
  localparam int PROD_W = LEN_W + 1 + DIR_W;
  localparam int STEP_W = PROD_W - DIR_FRAC;
  localparam int SUM_W  = STEP_W + 1;

  localparam int ORG_LSB = 0;
  localparam int DIR_LSB = 3 * POS_W;
  localparam int CTR_LSB = 3 * POS_W + 3 * DIR_W;
  localparam int IN_W    = 6 * POS_W + 3 * DIR_W;
  localparam int OUT_W   = 3 * POS_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_RADIUS = 1'b0;

  typedef struct packed {
    logic [2:0][POS_W-1:0] org;
    logic [2:0][DIR_W-1:0] dir;
    logic [T_W-1:0]        t;
    logic                  hit;
  } ray_side_t;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] data;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsfc_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, side payload alongside.
// Depends on rsfc_pkg.
`default_nettype none

module rsfc_sqrt_pipe (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [rsfc_pkg::RADIC_W-1:0] in_rad,
  input  wire rsfc_pkg::ray_side_t          in_side,
  output logic                              out_valid,
  output logic [rsfc_pkg::ROOT_W-1:0]       out_root,
  output rsfc_pkg::ray_side_t               out_side
);

  localparam int NS = rsfc_pkg::ROOT_W;

  logic                         vld_r  [NS];
  logic [rsfc_pkg::REM_W-1:0]   rem_r  [NS];
  logic [rsfc_pkg::ROOT_W-1:0]  root_r [NS];
  logic [rsfc_pkg::RADIC_W-1:0] rad_r  [NS];
  rsfc_pkg::ray_side_t          side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                         vld_p;
    logic [rsfc_pkg::REM_W-1:0]   rem_p;
    logic [rsfc_pkg::ROOT_W-1:0]  root_p;
    logic [rsfc_pkg::RADIC_W-1:0] rad_p;
    rsfc_pkg::ray_side_t          side_p;
    logic [rsfc_pkg::REM_W+1:0]   cur;
    logic [rsfc_pkg::REM_W+1:0]   trial;
    logic [rsfc_pkg::REM_W+1:0]   diff;
    logic [rsfc_pkg::REM_W-1:0]   rem_nxt;
    logic [rsfc_pkg::ROOT_W-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = in_rad;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_comb begin
      cur   = {rem_p, rad_p[rsfc_pkg::RADIC_W-1-2*k -: 2]};
      trial = {2'b00, root_p, 2'b01};
      diff  = cur - trial;
      if (cur >= trial) begin
        rem_nxt  = diff[rsfc_pkg::REM_W-1:0];
        root_nxt = {root_p[rsfc_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cur[rsfc_pkg::REM_W-1:0];
        root_nxt = {root_p[rsfc_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

`default_nettype wire

// ===== rtl/core/ray_sphere_far_clip_top.sv =====
// Ray / sphere far-exit point: stream pipeline, radius register and output skid stage.
// Depends on rsfc_pkg and rsfc_sqrt_pipe.
//
//   channel   dir   width         contents
//   in_*      in    192 tdata     origin x/y/z, dir x/y/z, center x/y/z
//   out_*     out   72 tdata, 1   exit x/y/z; tuser hit
//   cfg_*     APB   32 data       sphere_radius at byte address 0
//
// One ray per cycle sustained while the skid stage is empty.
// Most of the pipeline depth is the square root unit, one root bit per stage over 28 stages.
// Reset clears all valid bits and the radius; it takes effect at the next edge.
// A stalled output fills the skid stage; in_tready drops only while it is full,
// and the whole pipeline holds in place until it drains.
`default_nettype none

module ray_sphere_far_clip_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y, center_z
  input  wire logic [rsfc_pkg::IN_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // exit_x, exit_y, exit_z
  output logic [rsfc_pkg::OUT_W-1:0]          out_tdata,
  // hit
  output logic                                out_tuser,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [rsfc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [rsfc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rsfc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int POS_W = rsfc_pkg::POS_W;
  localparam int DIR_W = rsfc_pkg::DIR_W;

  logic en;

  logic [rsfc_pkg::RAD_W-1:0] radius_r;
  logic [rsfc_pkg::R2_W-1:0]  r2_r;

  logic                          v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  rsfc_pkg::ray_side_t           sd1_r, sd2_r, sd3_r, sd4_r, sd5_r, sd6_r;
  logic signed [rsfc_pkg::OFF_W-1:0] off1_r [3];
  logic signed [rsfc_pkg::OFF_W-1:0] off_nxt [3];
  logic signed [rsfc_pkg::PD_W-1:0]  pd2_r [3];
  logic signed [rsfc_pkg::PD_W-1:0]  pd_nxt [3];
  logic [rsfc_pkg::PM_W-1:0]     pm2_r [3];
  logic [rsfc_pkg::PM_W-1:0]     pm_nxt [3];
  logic [rsfc_pkg::DOT_W-1:0]    dot3_r, dot_nxt;
  logic [rsfc_pkg::MAG_W-1:0]    mag3_r, mag4_r, mag5_r, mag_nxt;
  logic [rsfc_pkg::DOT_W-1:0]    dot_rnd;
  logic                          neg4_r, neg5_r;
  logic [rsfc_pkg::TSQ_W-1:0]    tsq5_r;
  logic [rsfc_pkg::RS_W-1:0]     rs_nxt;
  logic [rsfc_pkg::RADIC_W-1:0]  rad6_r;

  logic                          sq_valid;
  logic [rsfc_pkg::ROOT_W-1:0]   sq_root;
  rsfc_pkg::ray_side_t           sq_side;

  logic [rsfc_pkg::LEN_W-1:0]    len7_r;
  logic [2:0][POS_W-1:0]         org7_r, org8_r;
  logic [2:0][DIR_W-1:0]         dir7_r;
  logic                          hit7_r, hit8_r;
  logic signed [rsfc_pkg::PROD_W-1:0] prod8_r [3];
  logic signed [rsfc_pkg::PROD_W-1:0] prod_nxt [3];
  rsfc_pkg::res_t                res9_r, res_nxt;

  rsfc_pkg::res_t out_res_r, skid_res_r;
  logic           out_valid_r, skid_valid_r;

  // configuration
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      r2_r     <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[rsfc_pkg::CFG_ADDR_W-1:2] == rsfc_pkg::REG_RADIUS) begin
        radius_r <= cfg_pwdata[rsfc_pkg::RAD_W-1:0];
      end
      r2_r <= radius_r * radius_r;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[rsfc_pkg::CFG_ADDR_W-1:2] == rsfc_pkg::REG_RADIUS) begin
      cfg_prdata = {{(rsfc_pkg::CFG_DATA_W-rsfc_pkg::RAD_W){1'b0}}, radius_r};
    end
  end

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // datapath
  always_comb begin
    logic [POS_W-1:0] o, c;
    logic signed [DIR_W-1:0] d;
    logic signed [rsfc_pkg::PSQ_W-1:0] sq;
    dot_nxt = '0;
    mag_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      o = in_tdata[rsfc_pkg::ORG_LSB + i*POS_W +: POS_W];
      c = in_tdata[rsfc_pkg::CTR_LSB + i*POS_W +: POS_W];
      off_nxt[i] = $signed({c[POS_W-1], c}) - $signed({o[POS_W-1], o});
      d = $signed(sd1_r.dir[i]);
      pd_nxt[i] = off1_r[i] * d;
      sq = off1_r[i] * off1_r[i];
      pm_nxt[i] = sq[rsfc_pkg::PM_W-1:0];
      dot_nxt = dot_nxt + {{2{pd2_r[i][rsfc_pkg::PD_W-1]}}, pd2_r[i]};
      mag_nxt = mag_nxt + {1'b0, pm2_r[i]};
    end
    dot_rnd = dot3_r + rsfc_pkg::DOT_W'(1 << (rsfc_pkg::DIR_FRAC - 1));
    rs_nxt  = {{(rsfc_pkg::RS_W-rsfc_pkg::R2_W){1'b0}}, r2_r}
            + {3'b000, tsq5_r}
            - {{(rsfc_pkg::RS_W-rsfc_pkg::MAG_W){1'b0}}, mag5_r};
  end

  always_comb begin
    logic signed [DIR_W-1:0] d;
    logic signed [rsfc_pkg::PROD_W-1:0] rp;
    logic [rsfc_pkg::STEP_W-1:0] step;
    logic [rsfc_pkg::SUM_W-1:0]  sum;
    logic [POS_W-1:0]            sat;
    res_nxt.hit  = hit8_r;
    res_nxt.data = '0;
    for (int i = 0; i < 3; i++) begin
      d  = $signed(dir7_r[i]);
      prod_nxt[i] = $signed({1'b0, len7_r}) * d;
      rp   = prod8_r[i] + rsfc_pkg::PROD_W'(1 << (rsfc_pkg::DIR_FRAC - 1));
      step = rp[rsfc_pkg::PROD_W-1:rsfc_pkg::DIR_FRAC];
      sum  = {{(rsfc_pkg::SUM_W-POS_W){org8_r[i][POS_W-1]}}, org8_r[i]}
           + {step[rsfc_pkg::STEP_W-1], step};
      if (!sum[rsfc_pkg::SUM_W-1] && (sum[rsfc_pkg::SUM_W-2:POS_W-1] != '0)) begin
        sat = {1'b0, {(POS_W-1){1'b1}}};
      end else if (sum[rsfc_pkg::SUM_W-1] && (sum[rsfc_pkg::SUM_W-2:POS_W-1] != '1)) begin
        sat = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        sat = sum[POS_W-1:0];
      end
      if (hit8_r) begin
        res_nxt.data[i*POS_W +: POS_W] = sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= sq_valid;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sd1_r.org[i] <= in_tdata[rsfc_pkg::ORG_LSB + i*POS_W +: POS_W];
        sd1_r.dir[i] <= in_tdata[rsfc_pkg::DIR_LSB + i*DIR_W +: DIR_W];
        off1_r[i]    <= off_nxt[i];
        pd2_r[i]     <= pd_nxt[i];
        pm2_r[i]     <= pm_nxt[i];
        prod8_r[i]   <= prod_nxt[i];
      end
      sd1_r.t   <= '0;
      sd1_r.hit <= 1'b0;
      sd2_r  <= sd1_r;
      sd3_r  <= sd2_r;
      dot3_r <= dot_nxt;
      mag3_r <= mag_nxt;
      sd4_r.org <= sd3_r.org;
      sd4_r.dir <= sd3_r.dir;
      sd4_r.hit <= sd3_r.hit;
      sd4_r.t   <= dot_rnd[rsfc_pkg::DOT_W-3:rsfc_pkg::DIR_FRAC];
      neg4_r    <= dot3_r[rsfc_pkg::DOT_W-1];
      mag4_r    <= mag3_r;
      sd5_r     <= sd4_r;
      neg5_r    <= neg4_r;
      mag5_r    <= mag4_r;
      tsq5_r    <= sd4_r.t * sd4_r.t;
      sd6_r.org <= sd5_r.org;
      sd6_r.dir <= sd5_r.dir;
      sd6_r.t   <= sd5_r.t;
      sd6_r.hit <= !neg5_r && !rs_nxt[rsfc_pkg::RS_W-1];
      rad6_r    <= rs_nxt[rsfc_pkg::RADIC_W-1:0];
      len7_r <= {2'b00, sq_side.t} + {1'b0, sq_root};
      org7_r <= sq_side.org;
      dir7_r <= sq_side.dir;
      hit7_r <= sq_side.hit;
      org8_r <= org7_r;
      hit8_r <= hit7_r;
      res9_r <= res_nxt;
    end
  end

  rsfc_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_rad    (rad6_r),
    .in_side   (sd6_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (v9_r) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_res_r <= skid_res_r;
      end
    end else if (v9_r) begin
      if (out_valid_r && !out_tready) begin
        skid_res_r <= res9_r;
      end else begin
        out_res_r <= res9_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.data;
  assign out_tuser  = out_res_r.hit;

  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid stage filled without an output stall");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_tready |=> skid_valid_r && $stable(skid_res_r))
    else $error("skid stage lost or changed its transfer during a stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.hit |-> out_res_r.data == '0)
    else $error("miss result carries nonzero coordinates");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for ray_sphere_far_clip_top: directed rays from a table, then
// random rays checked against an in-bench far-exit predictor over several radius settings.
// Depends on rsfc_pkg and the ray_sphere_far_clip_top RTL.
`timescale 1ns / 100ps

module tb_top;
  import rsfc_pkg::*;

  localparam int PIPE_LAT       = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int RAND_PER_PHASE = 90;
  localparam int N_PHASES       = 5;
  localparam int P_MAX          = 8388607;
  localparam int P_MIN          = -8388608;
  localparam int D_ONE          = 1 << DIR_FRAC;

  localparam logic [CFG_ADDR_W-1:0] RADIUS_ADDR = CFG_ADDR_W'(4 * REG_RADIUS);
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR  = CFG_ADDR_W'(4);

  localparam longint POS_HI    = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_LO    = -(64'sd1 <<< (POS_W - 1));
  localparam longint HALF_STEP = 64'sd1 <<< (DIR_FRAC - 1);

  typedef struct packed {
    logic [POS_W-1:0] cz, cy, cx;
    logic [DIR_W-1:0] dz, dy, dx;
    logic [POS_W-1:0] oz, oy, ox;
  } ray_t;

  typedef struct {
    logic [31:0] word;
    ray_t        ray;
    bit          typed;
    res_t        want;
  } plan_row_t;

  localparam res_t MISS = '0;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  res_t             exits_due[$];
  int               errs = 0;
  logic [RAD_W-1:0] radius_now = '0;
  logic [31:0]      radius_word = '0;
  int               tx_gap_pct = 0;
  bit               rx_idle_on = 1'b0;
  int               hold_asked = 0;

  ray_sphere_far_clip_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    errs++;
    if (errs <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic longint clip_pos(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic longint unsigned isqrt_floor(input longint unsigned n);
    longint unsigned root, trial;
    int b;
    root = 0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic res_t predict_exit(input ray_t r, input logic [RAD_W-1:0] rad);
    longint o[3], d[3], off[3];
    longint dot, mag2, t, dist2, r2, len, p;
    res_t res;
    int i;
    o[0] = $signed(r.ox);
    o[1] = $signed(r.oy);
    o[2] = $signed(r.oz);
    d[0] = $signed(r.dx);
    d[1] = $signed(r.dy);
    d[2] = $signed(r.dz);
    off[0] = longint'($signed(r.cx)) - o[0];
    off[1] = longint'($signed(r.cy)) - o[1];
    off[2] = longint'($signed(r.cz)) - o[2];
    dot = 0;
    mag2 = 0;
    for (i = 0; i < 3; i++) begin
      dot += off[i] * d[i];
      mag2 += off[i] * off[i];
    end
    res = MISS;
    if (dot >= 0) begin
      t = (dot + HALF_STEP) >>> DIR_FRAC;
      dist2 = mag2 - t * t;
      r2 = longint'(rad) * longint'(rad);
      if (dist2 <= r2) begin
        len = t + longint'(isqrt_floor(r2 - dist2));
        for (i = 0; i < 3; i++) begin
          p = clip_pos(o[i] + ((len * d[i] + HALF_STEP) >>> DIR_FRAC));
          res.data[i*POS_W +: POS_W] = p[POS_W-1:0];
        end
        res.hit = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic ray_t mk_ray(input int ox, oy, oz, dx, dy, dz, cx, cy, cz);
    ray_t r;
    r.ox = ox[POS_W-1:0];
    r.oy = oy[POS_W-1:0];
    r.oz = oz[POS_W-1:0];
    r.dx = dx[DIR_W-1:0];
    r.dy = dy[DIR_W-1:0];
    r.dz = dz[DIR_W-1:0];
    r.cx = cx[POS_W-1:0];
    r.cy = cy[POS_W-1:0];
    r.cz = cz[POS_W-1:0];
    return r;
  endfunction

  function automatic res_t exit_at(input int x, y, z);
    res_t res;
    res.hit = 1'b1;
    res.data = {z[POS_W-1:0], y[POS_W-1:0], x[POS_W-1:0]};
    return res;
  endfunction

  function automatic plan_row_t plan_row(input logic [31:0] word, input ray_t r,
                                         input bit typed, input res_t want);
    plan_row_t row;
    row.word = word;
    row.ray = r;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic int rand_coord(input int span);
    return int'($urandom_range(0, 2 * span - 1)) - span;
  endfunction

  // Mostly rays aimed near the center (within two radii, a few reversed), some random, some raw bits.
  function automatic ray_t random_ray(input logic [RAD_W-1:0] rad);
    int kind, span, i;
    int org[3], ctr[3], dv[3];
    real v[3];
    real len2, nrm, jit;
    kind = $urandom_range(0, 99);
    if (kind >= 90)
      return ray_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: span = 1 << 10;
      1: span = 1 << 16;
      default: span = 1 << 23;
    endcase
    len2 = 0.0;
    for (i = 0; i < 3; i++) begin
      org[i] = rand_coord(span);
      if (kind < 70) begin
        ctr[i] = int'(clip_pos(longint'(org[i]) + rand_coord(span)));
        jit = real'(int'($urandom_range(0, 2000)) - 1000) / 500.0 * real'(rad);
        v[i] = real'(ctr[i]) + jit - real'(org[i]);
      end else begin
        ctr[i] = rand_coord(1 << 23);
        v[i] = real'(int'($urandom_range(0, 2000)) - 1000);
      end
      len2 += v[i] * v[i];
    end
    nrm = $sqrt(len2);
    if (kind < 7) nrm = -nrm;
    if (len2 < 1.0) begin
      v = '{1.0, 0.0, 0.0};
      nrm = 1.0;
    end
    for (i = 0; i < 3; i++) dv[i] = int'(v[i] * real'(D_ONE) / nrm);
    return mk_ray(org[0], org[1], org[2], dv[0], dv[1], dv[2], ctr[0], ctr[1], ctr[2]);
  endfunction

  task automatic cfg_xfer(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                          input logic [CFG_DATA_W-1:0] wdata,
                          output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_radius_readback();
    logic [CFG_DATA_W-1:0] rd;
    cfg_xfer(1'b0, RADIUS_ADDR, '0, rd);
    if (rd !== CFG_DATA_W'(radius_now))
      log_mismatch($sformatf("radius readback got %0h want %0h", rd, radius_now));
  endtask

  task automatic settle_pipe();
    in_tvalid <= 1'b0;
    while (exits_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic program_radius(input logic [31:0] word);
    logic [CFG_DATA_W-1:0] rd;
    settle_pipe();
    cfg_xfer(1'b1, RADIUS_ADDR, word, rd);
    radius_word = word;
    radius_now = word[RAD_W-1:0];
    check_radius_readback();
  endtask

  task automatic feed_ray(input ray_t r, input bit typed, input res_t want);
    in_tvalid <= 1'b1;
    in_tdata <= r;
    do @(posedge clk); while (in_tready !== 1'b1);
    exits_due.push_back(typed ? want : predict_exit(r, radius_now));
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin : exit_sink
    int hold_done, hold_left, stall_left;
    hold_done = 0;
    hold_left = 0;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = int'($urandom_range(1, 13)) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : exit_check
    res_t want;
    int i;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (exits_due.size() == 0) begin
        log_mismatch("result transfer with nothing due");
      end else begin
        want = exits_due.pop_front();
        if (out_tuser !== want.hit)
          log_mismatch($sformatf("hit got %b want %b", out_tuser, want.hit));
        for (i = 0; i < 3; i++)
          if (out_tdata[i*POS_W +: POS_W] !== want.data[i*POS_W +: POS_W])
            log_mismatch($sformatf("exit[%0d] got %0d want %0d", i,
                                   $signed(out_tdata[i*POS_W +: POS_W]),
                                   $signed(want.data[i*POS_W +: POS_W])));
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    logic [CFG_DATA_W-1:0] rd;
    int ph, k;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    plan.push_back(plan_row(0, mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, exit_at(0, 0, 0)));
    plan.push_back(plan_row(0, mk_ray(0, 0, 0, D_ONE, 0, 0, -256, 0, 0), 1, MISS));
    plan.push_back(plan_row(0, mk_ray(0, 0, 0, D_ONE, 0, 0, 2560, 0, 0), 1,
                            exit_at(2560, 0, 0)));
    plan.push_back(plan_row(0, mk_ray(0, 0, 0, 32767, 0, 0, 2560, 0, 0), 0, MISS));
    plan.push_back(plan_row(0, mk_ray(1000, -1000, 0, -32768, 0, 0, -2560, 0, 0), 0, MISS));
    plan.push_back(plan_row(256, mk_ray(0, 0, 0, D_ONE, 0, 0, 2560, 0, 0), 1,
                            exit_at(2816, 0, 0)));
    plan.push_back(plan_row(256, mk_ray(0, 0, 0, D_ONE, 0, 0, 2560, 2560, 0), 1, MISS));
    plan.push_back(plan_row(256, mk_ray(0, 0, 0, D_ONE, 0, 0, 2560, 256, 0), 1,
                            exit_at(2560, 0, 0)));
    plan.push_back(plan_row(256, mk_ray(0, 0, 0, D_ONE, 0, 0, 2560, 257, 0), 1, MISS));
    plan.push_back(plan_row(256, mk_ray(P_MAX, 0, 0, D_ONE, 0, 0, P_MAX, 0, 0), 1,
                            exit_at(P_MAX, 0, 0)));
    plan.push_back(plan_row(256, mk_ray(P_MIN, 0, 0, -D_ONE, 0, 0, P_MIN, 0, 0), 1,
                            exit_at(P_MIN, 0, 0)));
    plan.push_back(plan_row(256, mk_ray(0, P_MIN, P_MAX, 0, 0, D_ONE, 0, P_MIN, P_MAX), 1,
                            exit_at(0, P_MIN, P_MAX)));
    plan.push_back(plan_row(32'hFFFF_FFFF, mk_ray(P_MIN, P_MIN, P_MIN, D_ONE, D_ONE, D_ONE,
                            P_MAX, P_MAX, P_MAX), 0, MISS));
    plan.push_back(plan_row(32'hFFFF_FFFF, mk_ray(P_MAX, P_MAX, P_MAX, -D_ONE, -D_ONE, -D_ONE,
                            P_MIN, P_MIN, P_MIN), 0, MISS));
    plan.push_back(plan_row(32'hFFFF_FFFF, mk_ray(P_MAX, P_MAX, P_MAX, D_ONE, 0, 0,
                            P_MIN, P_MIN, P_MIN), 1, MISS));
    plan.push_back(plan_row(32'hFFFF_FFFF, mk_ray(0, 0, 0, 0, 0, D_ONE, 1000, -2000, 3000),
                            0, MISS));
    plan.push_back(plan_row(32'hFFFF_FFFF, mk_ray(12345, -54321, 777, 32767, 32767, 32767,
                            -3000, 4000, 99999), 0, MISS));
    plan.push_back(plan_row(32'hFFFF_FFFF, mk_ray(P_MIN, P_MAX, P_MIN, -32768, D_ONE, 0,
                            P_MAX, P_MIN, P_MAX), 0, MISS));
    plan.push_back(plan_row(1, mk_ray(0, 0, 0, D_ONE, 0, 0, 2560, 0, 0), 1,
                            exit_at(2561, 0, 0)));
    plan.push_back(plan_row(1, mk_ray(-5000, 300, 0, 11585, 11585, 0, 100, 5400, 0), 0, MISS));

    tx_gap_pct = 30;
    rx_idle_on = 1'b1;
    foreach (plan[k]) begin
      if (plan[k].word !== radius_word) program_radius(plan[k].word);
      feed_ray(plan[k].ray, plan[k].typed, plan[k].want);
    end

    // a write to an unmapped address must leave the radius alone
    settle_pipe();
    cfg_xfer(1'b1, SPARE_ADDR, $urandom(), rd);
    check_radius_readback();

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          program_radius(32'h007F_FFFF);
          tx_gap_pct = 25;
          rx_idle_on = 1'b1;
        end
        1: begin
          program_radius(32'h0);
          tx_gap_pct = 0;
          rx_idle_on = 1'b1;
          hold_asked++;
        end
        2: begin
          program_radius($urandom());
          tx_gap_pct = 40;
          rx_idle_on = 1'b1;
        end
        3: begin
          program_radius($urandom_range(1, 8191));
          tx_gap_pct = 15;
          rx_idle_on = 1'b1;
        end
        default: begin
          program_radius($urandom_range(256, 65535));
          tx_gap_pct = 0;
          rx_idle_on = 1'b0;
        end
      endcase
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 2 && k == RAND_PER_PHASE / 2) settle_pipe();
        feed_ray(random_ray(radius_now), 1'b0, MISS);
      end
    end

    settle_pipe();
    if (errs == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rsfc_pkg.sv
rtl/core/rsfc_sqrt_pipe.sv
rtl/core/ray_sphere_far_clip_top.sv
tb/tb_top.sv
